[src/dsf_pkg.sv]
// ----------------------------------------------------------------------------
// dsf_pkg
// Types and constants shared by the damped spring force pipeline.
// ----------------------------------------------------------------------------
package dsf_pkg;

    typedef struct packed {
        logic               kind;
        logic [30:0]        rest_length;
        logic signed [31:0] pos_diff_x;
        logic signed [31:0] pos_diff_y;
        logic signed [31:0] pos_diff_z;
        logic signed [31:0] vel_diff_x;
        logic signed [31:0] vel_diff_y;
        logic signed [31:0] vel_diff_z;
    } t_spring_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               zero_length;
        logic               saturated;
    } t_force_out;

    typedef enum logic [1:0] {
        REG_SPRING_STIFFNESS  = 2'd0,
        REG_SPRING_DAMPING    = 2'd1,
        REG_CONTACT_STIFFNESS = 2'd2,
        REG_CONTACT_DAMPING   = 2'd3
    } t_reg_addr;

    localparam int unsigned FRONT_STAGES = 4;
    localparam int unsigned SQRT_STEPS   = 32;
    localparam int unsigned DIV_STEPS    = 64;
    localparam int unsigned BACK_STAGES  = 8;
    localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + BACK_STAGES;

    // Sideband carried through the square root stages
    typedef struct packed {
        logic [31:0]      k;
        logic [31:0]      c;
        logic [30:0]      rest;
        logic [63:0]      pm;
        logic             pn;
        logic [2:0][31:0] dmag;
        logic [2:0]       dneg;
        logic             zero;
    } t_sqrt_side;

    // Sideband carried through the divider stages
    typedef struct packed {
        logic [31:0] k;
        logic [31:0] c;
        logic [31:0] emag;
        logic        eneg;
        logic        pn;
        logic [2:0]  dneg;
        logic        zero;
    } t_div_side;

endpackage

[src/dsf_front.sv]
// ----------------------------------------------------------------------------
// dsf_front
// Magnitudes, squares, dot product terms and constant selection (4 stages).
// ----------------------------------------------------------------------------
module dsf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  dsf_pkg::t_spring_in  i_item,
    input  logic [31:0]          i_spring_k,
    input  logic [31:0]          i_spring_c,
    input  logic [31:0]          i_contact_k,
    input  logic [31:0]          i_contact_c,
    output logic                 o_valid,
    output logic [63:0]          o_sum_sq,
    output dsf_pkg::t_sqrt_side  o_side
);

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    logic             r1_v, r2_v, r3_v, r4_v;
    logic             r1_kind, r2_kind, r3_kind;
    logic [30:0]      r1_rest, r2_rest, r3_rest;
    logic [2:0][31:0] r1_dmag, r2_dmag, r3_dmag;
    logic [2:0]       r1_dneg, r2_dneg, r3_dneg;
    logic [2:0][31:0] r1_vmag;
    logic [2:0]       r1_vneg;
    logic [2:0][63:0] r2_sq, r2_pr;
    logic [2:0]       r2_psn;
    logic [63:0]      r3_s, r3_ppos, r3_pneg;
    logic [63:0]      r4_s;
    dsf_pkg::t_sqrt_side r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end

        r1_kind    <= i_item.kind;
        r1_rest    <= i_item.rest_length;
        r1_dmag[0] <= mag32(i_item.pos_diff_x);
        r1_dmag[1] <= mag32(i_item.pos_diff_y);
        r1_dmag[2] <= mag32(i_item.pos_diff_z);
        r1_dneg    <= {i_item.pos_diff_z[31], i_item.pos_diff_y[31], i_item.pos_diff_x[31]};
        r1_vmag[0] <= mag32(i_item.vel_diff_x);
        r1_vmag[1] <= mag32(i_item.vel_diff_y);
        r1_vmag[2] <= mag32(i_item.vel_diff_z);
        r1_vneg    <= {i_item.vel_diff_z[31], i_item.vel_diff_y[31], i_item.vel_diff_x[31]};

        for (int i = 0; i < 3; i++) begin
            r2_sq[i]  <= 64'(r1_dmag[i]) * 64'(r1_dmag[i]);
            r2_pr[i]  <= 64'(r1_dmag[i]) * 64'(r1_vmag[i]);
            r2_psn[i] <= r1_dneg[i] ^ r1_vneg[i];
        end
        r2_kind <= r1_kind;
        r2_rest <= r1_rest;
        r2_dmag <= r1_dmag;
        r2_dneg <= r1_dneg;

        r3_s    <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        r3_ppos <= (r2_psn[0] ? 64'd0 : r2_pr[0]) + (r2_psn[1] ? 64'd0 : r2_pr[1])
                 + (r2_psn[2] ? 64'd0 : r2_pr[2]);
        r3_pneg <= (r2_psn[0] ? r2_pr[0] : 64'd0) + (r2_psn[1] ? r2_pr[1] : 64'd0)
                 + (r2_psn[2] ? r2_pr[2] : 64'd0);
        r3_kind <= r2_kind;
        r3_rest <= r2_rest;
        r3_dmag <= r2_dmag;
        r3_dneg <= r2_dneg;

        r4_s         <= r3_s;
        r4_side.k    <= r3_kind ? i_contact_k : i_spring_k;
        r4_side.c    <= r3_kind ? i_contact_c : i_spring_c;
        r4_side.rest <= r3_rest;
        r4_side.pn   <= r3_pneg > r3_ppos;
        r4_side.pm   <= (r3_pneg > r3_ppos) ? (r3_pneg - r3_ppos) : (r3_ppos - r3_pneg);
        r4_side.dmag <= r3_dmag;
        r4_side.dneg <= r3_dneg;
        r4_side.zero <= (r3_s == 64'd0);
    end

    assign o_valid  = r4_v;
    assign o_sum_sq = r4_s;
    assign o_side   = r4_side;

endmodule

[src/dsf_sqrt.sv]
// ----------------------------------------------------------------------------
// dsf_sqrt
// Integer square root, one result bit per stage (32 stages).
// ----------------------------------------------------------------------------
module dsf_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [63:0]          i_sum_sq,
    input  dsf_pkg::t_sqrt_side  i_side,
    output logic                 o_valid,
    output logic [31:0]          o_root,
    output dsf_pkg::t_sqrt_side  o_side
);

    localparam int unsigned N = dsf_pkg::SQRT_STEPS;

    logic                r_v    [0:N-1];
    logic [31:0]         r_rem  [0:N-1];
    logic [31:0]         r_root [0:N-1];
    logic [63:0]         r_s    [0:N-1];
    dsf_pkg::t_sqrt_side r_side [0:N-1];

    for (genvar j = 0; j < N; j++) begin : g_step
        logic                v_in;
        logic [31:0]         rem_in, root_in;
        logic [63:0]         s_in;
        dsf_pkg::t_sqrt_side side_in;
        logic [33:0]         rem_sh, test;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = 32'd0;
            assign root_in = 32'd0;
            assign s_in    = i_sum_sq;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign s_in    = r_s[j-1];
            assign side_in = r_side[j-1];
        end

        assign rem_sh = {rem_in, s_in[63:62]};
        assign test   = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= v_in;
            end
            if (rem_sh >= test) begin
                r_rem[j]  <= 32'(rem_sh - test);
                r_root[j] <= {root_in[30:0], 1'b1};
            end else begin
                r_rem[j]  <= rem_sh[31:0];
                r_root[j] <= {root_in[30:0], 1'b0};
            end
            r_s[j]    <= {s_in[61:0], 2'b00};
            r_side[j] <= side_in;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

[src/dsf_div.sv]
// ----------------------------------------------------------------------------
// dsf_div
// Restoring dividers: projected speed over length, one quotient bit per stage
// (64 stages), and the three unit vector lanes alongside, UNIT_FRAC + 1 bits each.
// ----------------------------------------------------------------------------
module dsf_div #(
    parameter int unsigned UNIT_FRAC = 30
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [31:0]                i_len,
    input  dsf_pkg::t_sqrt_side        i_side,
    output logic                       o_valid,
    output logic [63:0]                o_speed,
    output logic [2:0][UNIT_FRAC:0]    o_unit,
    output dsf_pkg::t_div_side         o_side
);

    localparam int unsigned N  = dsf_pkg::DIV_STEPS;
    localparam int unsigned UW = UNIT_FRAC + 1;

    logic                     r_v    [0:N-1];
    logic [31:0]              r_len  [0:N-1];
    logic [31:0]              r_rem  [0:N-1];
    logic [63:0]              r_pq   [0:N-1];
    logic [2:0][31:0]         r_urem [0:N-1];
    logic [2:0][UW-1:0]       r_u    [0:N-1];
    dsf_pkg::t_div_side       r_side [0:N-1];

    dsf_pkg::t_div_side entry_side;

    always_comb begin
        entry_side.k    = i_side.k;
        entry_side.c    = i_side.c;
        entry_side.eneg = {1'b0, i_side.rest} > i_len;
        entry_side.emag = ({1'b0, i_side.rest} > i_len) ? ({1'b0, i_side.rest} - i_len)
                                                         : (i_len - {1'b0, i_side.rest});
        entry_side.pn   = i_side.pn;
        entry_side.dneg = i_side.dneg;
        entry_side.zero = i_side.zero;
    end

    for (genvar j = 0; j < N; j++) begin : g_step
        logic               v_in;
        logic [31:0]        len_in, rem_in;
        logic [63:0]        pq_in;
        logic [2:0][31:0]   urem_in;
        logic [2:0][UW-1:0] u_in;
        dsf_pkg::t_div_side side_in;
        logic [32:0]        r2;
        logic               ge;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign len_in  = i_len;
            assign rem_in  = 32'd0;
            assign pq_in   = i_side.pm;
            assign urem_in = i_side.dmag;
            assign u_in    = '0;
            assign side_in = entry_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign len_in  = r_len[j-1];
            assign rem_in  = r_rem[j-1];
            assign pq_in   = r_pq[j-1];
            assign urem_in = r_urem[j-1];
            assign u_in    = r_u[j-1];
            assign side_in = r_side[j-1];
        end

        assign r2 = {rem_in, pq_in[63]};
        assign ge = r2 >= {1'b0, len_in};

        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [32:0] ur2;
            logic        uge;

            if (j == 0) begin : g_lead
                assign ur2 = {1'b0, urem_in[i]};
            end else begin : g_shift
                assign ur2 = {urem_in[i], 1'b0};
            end
            assign uge = ur2 >= {1'b0, len_in};

            always_ff @(posedge i_clk) begin
                if (j <= UNIT_FRAC) begin
                    r_urem[j][i] <= uge ? 32'(ur2 - {1'b0, len_in}) : ur2[31:0];
                    r_u[j][i]    <= {u_in[i][UW-2:0], uge};
                end else begin
                    r_urem[j][i] <= urem_in[i];
                    r_u[j][i]    <= u_in[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= v_in;
            end
            r_len[j]  <= len_in;
            r_rem[j]  <= ge ? 32'(r2 - {1'b0, len_in}) : r2[31:0];
            r_pq[j]   <= {pq_in[62:0], ge};
            r_side[j] <= side_in;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_speed = r_pq[N-1];
    assign o_unit  = r_u[N-1];
    assign o_side  = r_side[N-1];

endmodule

[src/dsf_back.sv]
// ----------------------------------------------------------------------------
// dsf_back
// Spring and damper terms, scaling along the unit vector, saturation
// (8 stages, the last is the result register).
// ----------------------------------------------------------------------------
module dsf_back #(
    parameter int unsigned UNIT_FRAC = 30
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [63:0]              i_speed,
    input  logic [2:0][UNIT_FRAC:0]  i_unit,
    input  dsf_pkg::t_div_side       i_side,
    output logic                     o_valid,
    output dsf_pkg::t_force_out      o_result
);

    localparam int unsigned UW = UNIT_FRAC + 1;

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic r1_eneg, r2_eneg, r3_eneg;
    logic r1_pn, r2_pn, r3_pn;
    logic r4_tneg, r5_tneg, r6_tneg, r7_tneg;
    logic [2:0] r1_dneg, r2_dneg, r3_dneg, r4_dneg, r5_dneg, r6_dneg, r7_dneg;
    logic r1_zero, r2_zero, r3_zero, r4_zero, r5_zero, r6_zero, r7_zero;
    logic [2:0][UW-1:0] r1_u, r2_u, r3_u, r4_u, r5_u;

    logic [47:0] r1_pk_hi, r1_pk_lo, r1_pc_a, r1_pc_b, r1_pc_c, r1_pc_d;
    logic [48:0] r2_h, r3_h;
    logic [63:0] r2_t1;
    logic [47:0] r2_t2;
    logic [63:0] r3_d;
    logic [63:0] r4_t;
    logic [63:0] r5_tmag;
    logic [2:0][63:0] r6_ll, r6_lh, r6_hl, r6_hh;
    logic [2:0][127:0] r7_prod;
    dsf_pkg::t_force_out r8_res;

    logic [63:0] c_t2_full;
    assign c_t2_full = 64'(r1_pc_c) + {r1_pc_d[31:0], 32'd0};

    logic [2:0][31:0] c_fout;
    logic [2:0]       c_sat;

    always_comb begin
        logic [127:0] q, lim;
        logic [32:0]  f;
        logic         fneg;
        for (int i = 0; i < 3; i++) begin
            q         = r7_prod[i] >> UNIT_FRAC;
            fneg      = (r7_tneg == r7_dneg[i]);
            lim       = fneg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            c_sat[i]  = q > lim;
            f         = c_sat[i] ? lim[32:0] : q[32:0];
            c_fout[i] = fneg ? 32'(33'd0 - f) : f[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0;
        end else begin
            r1_v <= i_valid; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v; r8_v <= r7_v;
        end

        r1_pk_hi <= 48'(i_side.k[31:16]) * 48'(i_side.emag);
        r1_pk_lo <= 48'(i_side.k[15:0]) * 48'(i_side.emag);
        r1_pc_a  <= 48'(i_side.c[31:16]) * 48'(i_speed[31:0]);
        r1_pc_b  <= 48'(i_side.c[31:16]) * 48'(i_speed[63:32]);
        r1_pc_c  <= 48'(i_side.c[15:0]) * 48'(i_speed[31:0]);
        r1_pc_d  <= 48'(i_side.c[15:0]) * 48'(i_speed[63:32]);
        r1_eneg  <= i_side.eneg;
        r1_pn    <= i_side.pn;
        r1_dneg  <= i_side.dneg;
        r1_zero  <= i_side.zero;
        r1_u     <= i_unit;

        r2_h    <= 49'(r1_pk_hi) + 49'(r1_pk_lo[47:16]);
        r2_t1   <= 64'(r1_pc_a) + {r1_pc_b[31:0], 32'd0};
        r2_t2   <= c_t2_full[63:16];
        r2_eneg <= r1_eneg; r2_pn <= r1_pn; r2_dneg <= r1_dneg;
        r2_zero <= r1_zero; r2_u <= r1_u;

        r3_d    <= r2_t1 + 64'(r2_t2);
        r3_h    <= r2_h;
        r3_eneg <= r2_eneg; r3_pn <= r2_pn; r3_dneg <= r2_dneg;
        r3_zero <= r2_zero; r3_u <= r2_u;

        r4_t    <= (r3_eneg ? (64'd0 - 64'(r3_h)) : 64'(r3_h))
                 + (r3_pn ? (64'd0 - r3_d) : r3_d);
        r4_dneg <= r3_dneg; r4_zero <= r3_zero; r4_u <= r3_u;

        r5_tneg <= r4_t[63];
        r5_tmag <= r4_t[63] ? (64'd0 - r4_t) : r4_t;
        r5_dneg <= r4_dneg; r5_zero <= r4_zero; r5_u <= r4_u;

        for (int i = 0; i < 3; i++) begin
            r6_ll[i] <= 64'(r5_tmag[31:0])  * 64'(64'(r5_u[i]) & 64'hFFFF_FFFF);
            r6_lh[i] <= 64'(r5_tmag[31:0])  * 64'(64'(r5_u[i]) >> 32);
            r6_hl[i] <= 64'(r5_tmag[63:32]) * 64'(64'(r5_u[i]) & 64'hFFFF_FFFF);
            r6_hh[i] <= 64'(r5_tmag[63:32]) * 64'(64'(r5_u[i]) >> 32);
        end
        r6_tneg <= r5_tneg; r6_dneg <= r5_dneg; r6_zero <= r5_zero;

        for (int i = 0; i < 3; i++) begin
            r7_prod[i] <= 128'(r6_ll[i]) + (128'(r6_lh[i]) << 32)
                        + (128'(r6_hl[i]) << 32) + (128'(r6_hh[i]) << 64);
        end
        r7_tneg <= r6_tneg; r7_dneg <= r6_dneg; r7_zero <= r6_zero;

        if (r7_zero) begin
            r8_res <= '{force_x: 32'sd0, force_y: 32'sd0, force_z: 32'sd0,
                        zero_length: 1'b1, saturated: 1'b0};
        end else begin
            r8_res <= '{force_x: c_fout[0], force_y: c_fout[1], force_z: c_fout[2],
                        zero_length: 1'b0, saturated: |c_sat};
        end
    end

    assign o_valid  = r8_v;
    assign o_result = r8_res;

endmodule

[src/damped_spring_force.sv]
// ----------------------------------------------------------------------------
// damped_spring_force
// Hooke spring with dashpot: force on the first end point of one spring per
// item, signed Q16.16, saturated.
//
//   channel   ports                                    direction
//   item      start, busy, i_spring                    in/out
//   result    o_valid, o_result                        out
//   config    psel, penable, pwrite, paddr, pwdata,    in/out
//             prdata, pready
//
// One item per cycle; each result passes the front multiply stages, then the
// 32-stage square root and the 64-stage divider, then the back multiply
// stages. busy is always low. Reset empties the pipeline and clears the
// four constants. Results are not held back.
// ----------------------------------------------------------------------------
module damped_spring_force #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dsf_pkg::t_spring_in  i_spring,
    output logic                 o_valid,
    output dsf_pkg::t_force_out  o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int unsigned UNIT_FRAC = DATA_WIDTH - 2;

    logic [31:0] r_spring_k, r_spring_c, r_contact_k, r_contact_c;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_k  <= 32'd0;
            r_spring_c  <= 32'd0;
            r_contact_k <= 32'd0;
            r_contact_c <= 32'd0;
        end else if (psel && penable && pwrite) begin
            case (dsf_pkg::t_reg_addr'(paddr[3:2]))
                dsf_pkg::REG_SPRING_STIFFNESS:  r_spring_k  <= pwdata;
                dsf_pkg::REG_SPRING_DAMPING:    r_spring_c  <= pwdata;
                dsf_pkg::REG_CONTACT_STIFFNESS: r_contact_k <= pwdata;
                dsf_pkg::REG_CONTACT_DAMPING:   r_contact_c <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (dsf_pkg::t_reg_addr'(paddr[3:2]))
            dsf_pkg::REG_SPRING_STIFFNESS:  prdata = r_spring_k;
            dsf_pkg::REG_SPRING_DAMPING:    prdata = r_spring_c;
            dsf_pkg::REG_CONTACT_STIFFNESS: prdata = r_contact_k;
            dsf_pkg::REG_CONTACT_DAMPING:   prdata = r_contact_c;
            default:                        prdata = 32'd0;
        endcase
    end

    logic                front_v, sqrt_v, div_v;
    logic [63:0]         front_s;
    dsf_pkg::t_sqrt_side front_side, sqrt_side;
    logic [31:0]         sqrt_len;
    logic [63:0]         div_speed;
    logic [2:0][UNIT_FRAC:0] div_unit;
    dsf_pkg::t_div_side  div_side;

    dsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_item      (i_spring),
        .i_spring_k  (r_spring_k),
        .i_spring_c  (r_spring_c),
        .i_contact_k (r_contact_k),
        .i_contact_c (r_contact_c),
        .o_valid     (front_v),
        .o_sum_sq    (front_s),
        .o_side      (front_side)
    );

    dsf_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_v),
        .i_sum_sq (front_s),
        .i_side   (front_side),
        .o_valid  (sqrt_v),
        .o_root   (sqrt_len),
        .o_side   (sqrt_side)
    );

    dsf_div #(.UNIT_FRAC(UNIT_FRAC)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_v),
        .i_len   (sqrt_len),
        .i_side  (sqrt_side),
        .o_valid (div_v),
        .o_speed (div_speed),
        .o_unit  (div_unit),
        .o_side  (div_side)
    );

    dsf_back #(.UNIT_FRAC(UNIT_FRAC)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_v),
        .i_speed  (div_speed),
        .i_unit   (div_unit),
        .i_side   (div_side),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(dsf_pkg::PIPE_DEPTH) o_valid)
        else $error("item did not come out after the pipeline depth");

    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_length) |->
            (o_result.force_x == 32'sd0 && o_result.force_y == 32'sd0 &&
             o_result.force_z == 32'sd0 && !o_result.saturated))
        else $error("zero length result carries force or saturation");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.force_x == 32'h7FFF_FFFF || o_result.force_x == 32'h8000_0000 ||
             o_result.force_y == 32'h7FFF_FFFF || o_result.force_y == 32'h8000_0000 ||
             o_result.force_z == 32'h7FFF_FFFF || o_result.force_z == 32'h8000_0000))
        else $error("saturation flag without a clipped component");

endmodule

[verif/tb_damped_spring_force.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_damped_spring_force
// Drives spring items through the force pipeline with random gaps, predicts
// each untyped force from the spring constants held in the testbench, and
// compares every result field by field. Constants are changed between phases.
// ----------------------------------------------------------------------------
module tb_damped_spring_force;

    localparam int unsigned UNIT_FRAC = 30;
    localparam int unsigned LATENCY   = 108;
    localparam int unsigned WATCHDOG  = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    dsf_pkg::t_spring_in  i_spring;
    logic                 o_valid;
    dsf_pkg::t_force_out  o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    logic [31:0]         stiff_mesh, damp_mesh, stiff_contact, damp_contact;
    dsf_pkg::t_force_out force_queue[$];
    int                  err_count;
    int                  idle_cycles;
    bit                  no_gaps;

    typedef struct {
        dsf_pkg::t_spring_in item;
        bit                  typed;
        dsf_pkg::t_force_out force_exp;
    } t_row;

    damped_spring_force uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [32:0] mag_of(logic [31:0] raw);
        return raw[31] ? 33'h1_0000_0000 - raw : {1'b0, raw};
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic dsf_pkg::t_force_out spring_force(dsf_pkg::t_spring_in sp);
        logic [32:0]  dmag[3];
        logic         dneg[3];
        logic [32:0]  vmag;
        logic [127:0] s, ppos, pneg, pm, v, h, dd, tmag, u, f, lim;
        logic [63:0]  len;
        logic [31:0]  kk, cc, rr;
        logic [31:0]  pd[3], vd[3];
        logic         eneg, pn, tneg, fneg, sat;
        logic [127:0] emag;
        dsf_pkg::t_force_out r;
        pd = '{sp.pos_diff_x, sp.pos_diff_y, sp.pos_diff_z};
        vd = '{sp.vel_diff_x, sp.vel_diff_y, sp.vel_diff_z};
        s = 0; ppos = 0; pneg = 0; sat = 0;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            dmag[i] = mag_of(pd[i]);
            dneg[i] = pd[i][31];
            vmag    = mag_of(vd[i]);
            s += dmag[i] * dmag[i];
            if (dneg[i] != vd[i][31]) pneg += dmag[i] * vmag;
            else                      ppos += dmag[i] * vmag;
        end
        if (s == 0) begin
            r.zero_length = 1'b1;
            return r;
        end
        kk = sp.kind ? stiff_contact : stiff_mesh;
        cc = sp.kind ? damp_contact  : damp_mesh;
        rr = {1'b0, sp.rest_length};
        len  = root_floor(s[63:0]);
        eneg = rr > len;
        emag = eneg ? rr - len : len - rr;
        pn   = pneg > ppos;
        pm   = pn ? pneg - ppos : ppos - pneg;
        v    = pm / len;
        h    = (kk * emag) >> 16;
        dd   = (cc * v) >> 16;
        if (eneg == pn) begin
            tmag = h + dd;
            tneg = eneg && (tmag != 0);
        end else if (h >= dd) begin
            tmag = h - dd;
            tneg = eneg && (tmag != 0);
        end else begin
            tmag = dd - h;
            tneg = pn;
        end
        for (int i = 0; i < 3; i++) begin
            u    = (dmag[i] << UNIT_FRAC) / len;
            f    = (tmag * u) >> UNIT_FRAC;
            fneg = (tneg == dneg[i]);
            lim  = fneg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (f > lim) begin
                f   = lim;
                sat = 1'b1;
            end
            if (i == 0) r.force_x = fneg ? -f[31:0] : f[31:0];
            if (i == 1) r.force_y = fneg ? -f[31:0] : f[31:0];
            if (i == 2) r.force_z = fneg ? -f[31:0] : f[31:0];
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        dsf_pkg::t_force_out want;
        if (i_rst_n && o_valid) begin
            if (force_queue.size() == 0) begin
                report_mismatch("unexpected result", o_result.force_x, 32'd0);
            end else begin
                want = force_queue.pop_front();
                if (o_result.force_x !== want.force_x)
                    report_mismatch("force_x", o_result.force_x, want.force_x);
                if (o_result.force_y !== want.force_y)
                    report_mismatch("force_y", o_result.force_y, want.force_y);
                if (o_result.force_z !== want.force_z)
                    report_mismatch("force_z", o_result.force_z, want.force_z);
                if (o_result.zero_length !== want.zero_length)
                    report_mismatch("zero_length", 32'(o_result.zero_length),
                                    32'(want.zero_length));
                if (o_result.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(o_result.saturated),
                                    32'(want.saturated));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("damped_spring_force verification failed");
            $finish;
        end
    end

    task automatic write_reg(dsf_pkg::t_reg_addr idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            dsf_pkg::REG_SPRING_STIFFNESS:  stiff_mesh    = value;
            dsf_pkg::REG_SPRING_DAMPING:    damp_mesh     = value;
            dsf_pkg::REG_CONTACT_STIFFNESS: stiff_contact = value;
            dsf_pkg::REG_CONTACT_DAMPING:   damp_contact  = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_constants(logic [31:0] km, logic [31:0] cm,
                                 logic [31:0] kc, logic [31:0] cc);
        write_reg(dsf_pkg::REG_SPRING_STIFFNESS, km);
        write_reg(dsf_pkg::REG_SPRING_DAMPING, cm);
        write_reg(dsf_pkg::REG_CONTACT_STIFFNESS, kc);
        write_reg(dsf_pkg::REG_CONTACT_DAMPING, cc);
    endtask

    task automatic send_spring(dsf_pkg::t_spring_in sp, bit typed,
                               dsf_pkg::t_force_out want);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start    <= 1'b1;
        i_spring <= sp;
        do @(posedge i_clk); while (busy);
        force_queue.push_back(typed ? want : spring_force(sp));
        @(negedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (force_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_diff();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic dsf_pkg::t_spring_in rand_spring();
        dsf_pkg::t_spring_in sp;
        sp.kind        = 1'($urandom);
        sp.rest_length = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h40000));
        sp.pos_diff_x  = rand_diff();
        sp.pos_diff_y  = $urandom_range(0, 7) == 0 ? 32'd0 : rand_diff();
        sp.pos_diff_z  = $urandom_range(0, 7) == 0 ? 32'd0 : rand_diff();
        sp.vel_diff_x  = rand_diff();
        sp.vel_diff_y  = rand_diff();
        sp.vel_diff_z  = rand_diff();
        return sp;
    endfunction

    initial begin
        t_row                rows[$];
        t_row                row;
        dsf_pkg::t_force_out zero_res;
        err_count = 0; idle_cycles = 0; no_gaps = 0;
        stiff_mesh = 0; damp_mesh = 0; stiff_contact = 0; damp_contact = 0;
        i_rst_n = 1'b0; start = 1'b0; i_spring = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        zero_res = '0;
        zero_res.zero_length = 1'b1;
        // constants still zero after reset: no force
        row = '{item: '0, typed: 1, force_exp: zero_res};
        rows.push_back(row);
        row.item = '{1'b1, 31'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'd1};
        rows.push_back(row);
        row.item = '{1'b0, 31'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd5, 32'd0, 32'd0};
        row.force_exp = '0;
        rows.push_back(row);
        foreach (rows[i]) send_spring(rows[i].item, rows[i].typed, rows[i].force_exp);
        drain();

        set_constants(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000);
        rows.delete();
        row.typed = 0;
        for (int k = 0; k < 2; k++) begin
            row.item = '{1'(k), 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            rows.push_back(row);
            row.item = '{1'(k), 31'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            rows.push_back(row);
            row.item = '{1'(k), 31'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'd0,
                         32'h0000_4000, 32'd0, 32'hFFFF_C000};
            rows.push_back(row);
            row.item = '{1'(k), 31'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
                         32'd0, 32'd0, 32'd0};
            rows.push_back(row);
            row.item = '{1'(k), 31'd1, 32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0};
            rows.push_back(row);
            row.item = '{1'(k), 31'd0, 32'd0, 32'd0, 32'd0,
                         32'h1234_5678, 32'h8000_0000, 32'd0};
            rows.push_back(row);
        end
        foreach (rows[i]) send_spring(rows[i].item, rows[i].typed, rows[i].force_exp);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_constants(32'h0001_0000, 32'h0000_1000, 32'h0010_0000, 32'h0000_0100);
                1: set_constants(32'h0000_0001, 32'd0, 32'd0, 32'h0000_0001);
                2: set_constants($urandom, $urandom, $urandom, $urandom);
                3: set_constants(32'h00FF_FFFF & $urandom, 32'h0000_FFFF & $urandom,
                                 32'h00FF_FFFF & $urandom, 32'h0000_FFFF & $urandom);
                4: set_constants(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: set_constants(32'h0004_0000, 32'h0000_4000,
                                       32'h0040_0000, 32'h0004_0000);
            endcase
            no_gaps = (phase == 5);
            repeat (100) send_spring(rand_spring(), 0, zero_res);
            drain();
        end

        if (err_count == 0) $display("damped_spring_force verification clean");
        else $display("damped_spring_force verification failed");
        $finish;
    end

endmodule

[files.f]
src/dsf_pkg.sv
src/dsf_front.sv
src/dsf_sqrt.sv
src/dsf_div.sv
src/dsf_back.sv
src/damped_spring_force.sv
verif/tb_damped_spring_force.sv
